// File: design/gdlw_pkg.sv
`timescale 1ns / 1ps

package gdlw_pkg;

    // Sizes
    localparam int LIST_DEPTH_DEF  = 16;
    localparam int MAX_RESULTS     = 16;
    localparam int CMD_QUEUE_DEPTH = 2;

    // Input mode codes
    localparam logic [1:0] MODE_WRITE    = 2'd0;
    localparam logic [1:0] MODE_ACTIVATE = 2'd1;
    localparam logic [1:0] MODE_PASS     = 2'd2;

    // Register indexes (word addresses on the APB port)
    localparam logic [1:0] REG_BASE_ADDRESS   = 2'd0;
    localparam logic [1:0] REG_BYTES_PER_PASS = 2'd1;
    localparam logic [1:0] REG_LIST_LENGTH    = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_NONE        = 2'd0;
    localparam logic [1:0] ERR_PAST_LIST   = 2'd1;
    localparam logic [1:0] ERR_OFFSET      = 2'd2;
    localparam logic [1:0] ERR_NULL_SOURCE = 2'd3;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_ACTIVATE,
        OP_PASS
    } op_t;

    // Command handed from front to back
    typedef struct packed {
        op_t         op;
        logic [3:0]  index;
        logic [31:0] packed_offset;
        logic [31:0] length;
        logic [31:0] source;
    } cmd_t;

    // Configuration registers
    typedef struct packed {
        logic [31:0] base_address;
        logic [31:0] bytes_per_pass;
        logic [4:0]  list_length;
    } cfg_t;

    // One descriptor memory word
    typedef struct packed {
        logic [31:0] packed_offset;
        logic [31:0] length;
        logic [31:0] source;
    } desc_t;

    // One result word
    typedef struct packed {
        logic [31:0] copy_source;
        logic [31:0] copy_dest;
        logic [31:0] copy_bytes;
        logic [31:0] stream_position;
        logic        finished;
        logic [1:0]  error_code;
        logic        last;
    } res_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_NOTE,
        B_FETCH,
        B_CHECK,
        B_EMIT,
        B_FAULT
    } back_state_t;

endpackage

// File: design/gather_dma_list_walker.sv
`timescale 1ns / 1ps

// Scatter-gather descriptor walker. Input words carry a mode: 0 writes one descriptor
// slot, 1 activates the stream and rewinds the cursor, 2 runs one budgeted pass that
// returns 1 to 16 copy words, the final one flagged by last. Input words land in a
// two-deep command queue, so the producer keeps pushing while the walker works or a
// result waits. A pass starts, then steps each copy word through a descriptor memory
// read, bounds and null checks and a chunk emit; an inactive or zero-budget pass
// gives a single empty word. An error word is raised at the fetch step when the cursor
// is past the list, and at the check step when the offset or null-source check fails.
// Every word also waits while the previous result is still held by a low pop.
// Configuration (base_address at 0x0, bytes_per_pass at 0x4, list_length at 0x8)
// must only be written while no pass is in flight.
module gather_dma_list_walker
    import gdlw_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  mode,
    input  logic [3:0]  entry_index,
    input  logic [31:0] entry_packed_offset,
    input  logic [31:0] entry_length,
    input  logic [31:0] entry_source,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] copy_source,
    output logic [31:0] copy_dest,
    output logic [31:0] copy_bytes,
    output logic [31:0] stream_position,
    output logic        finished,
    output logic [1:0]  error_code,
    output logic        last
);

    cfg_t cfg;
    logic cmd_push;
    cmd_t cmd_in;
    logic cmd_full;
    logic cmd_valid;
    cmd_t cmd_out;
    logic cmd_pop;
    res_t result;

    gdlw_front #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_front (
        .clk                 (clk),
        .rst_n               (rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .push                (push),
        .full                (full),
        .mode                (mode),
        .entry_index         (entry_index),
        .entry_packed_offset (entry_packed_offset),
        .entry_length        (entry_length),
        .entry_source        (entry_source),
        .cfg                 (cfg),
        .cmd_push            (cmd_push),
        .cmd                 (cmd_in),
        .cmd_full            (cmd_full)
    );

    gdlw_cmd_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (cmd_push),
        .wr_cmd (cmd_in),
        .full   (cmd_full),
        .valid  (cmd_valid),
        .rd_cmd (cmd_out),
        .pop    (cmd_pop)
    );

    gdlw_back #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    assign copy_source     = result.copy_source;
    assign copy_dest       = result.copy_dest;
    assign copy_bytes      = result.copy_bytes;
    assign stream_position = result.stream_position;
    assign finished        = result.finished;
    assign error_code      = result.error_code;
    assign last            = result.last;

endmodule

// File: design/gdlw_front.sv
`timescale 1ns / 1ps

module gdlw_front
    import gdlw_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input words
    input  logic        push,
    output logic        full,
    input  logic [1:0]  mode,
    input  logic [3:0]  entry_index,
    input  logic [31:0] entry_packed_offset,
    input  logic [31:0] entry_length,
    input  logic [31:0] entry_source,
    // to command queue and back end
    output cfg_t        cfg,
    output logic        cmd_push,
    output cmd_t        cmd,
    input  logic        cmd_full
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic cfg_wr;
    logic accept;
    logic keep;

    // Register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_BASE_ADDRESS:   cfg_next.base_address   = pwdata;
                REG_BYTES_PER_PASS: cfg_next.bytes_per_pass = pwdata;
                REG_LIST_LENGTH:    cfg_next.list_length    = pwdata[4:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_BASE_ADDRESS:   prdata = cfg_reg.base_address;
            REG_BYTES_PER_PASS: prdata = cfg_reg.bytes_per_pass;
            REG_LIST_LENGTH:    prdata = {27'd0, cfg_reg.list_length};
            default:            prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

    // Classify incoming words; unknown modes and writes past the list are dropped
    assign full   = cmd_full;
    assign accept = push && !cmd_full;

    always_comb
    begin
        cmd.index         = entry_index;
        cmd.packed_offset = entry_packed_offset;
        cmd.length        = entry_length;
        cmd.source        = entry_source;
        unique case (mode)
            MODE_WRITE:
            begin
                cmd.op = OP_WRITE;
                keep   = (32'(entry_index) < LIST_DEPTH);
            end
            MODE_ACTIVATE:
            begin
                cmd.op = OP_ACTIVATE;
                keep   = 1'b1;
            end
            MODE_PASS:
            begin
                cmd.op = OP_PASS;
                keep   = 1'b1;
            end
            default:
            begin
                cmd.op = OP_PASS;
                keep   = 1'b0;
            end
        endcase
    end

    assign cmd_push = accept && keep;

endmodule

// File: design/gdlw_cmd_queue.sv
`timescale 1ns / 1ps

module gdlw_cmd_queue
    import gdlw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t wr_cmd,
    output logic full,
    output logic valid,
    output cmd_t rd_cmd,
    input  logic pop
);

    localparam int PW = (CMD_QUEUE_DEPTH > 1) ? $clog2(CMD_QUEUE_DEPTH) : 1;

    cmd_t          slot_reg [CMD_QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [PW:0]   count_reg;
    logic [PW:0]   count_next;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == (PW+1)'(CMD_QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign rd_cmd  = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(CMD_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(CMD_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

// File: design/gdlw_back.sv
`timescale 1ns / 1ps

module gdlw_back
    import gdlw_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic cmd_valid,
    input  cmd_t cmd,
    output logic cmd_pop,
    output logic empty,
    input  logic pop,
    output res_t result
);

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int NW = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

    back_state_t state_reg, state_next;
    logic          active_reg, active_next;
    logic [4:0]    cur_reg, cur_next;
    logic [31:0]   off_reg, off_next;
    logic [31:0]   pos_reg, pos_next;
    logic [31:0]   budget_reg, budget_next;
    logic [NW-1:0] n_reg, n_next;
    logic [31:0]   src_reg, src_next;
    logic [31:0]   packed_reg, packed_next;
    logic [31:0]   rem_reg, rem_next;
    logic [1:0]    err_reg, err_next;
    logic          fin_reg, fin_next;
    logic          out_valid_reg;
    res_t          res_reg;
    res_t          res_next;
    logic          out_push;
    logic          out_space;

    desc_t         desc_mem [LIST_DEPTH];
    desc_t         rd_desc_reg;
    logic          mem_we;
    logic          mem_re;

    logic [4:0]    eff_len;
    logic [5:0]    cur_inc;
    logic [31:0]   src_sum;
    logic          rem_le;
    logic          done;
    logic          stop;
    logic [31:0]   moved;

    // Effective list length is capped by the memory depth
    assign eff_len = (32'(cfg.list_length) < LIST_DEPTH) ? cfg.list_length : 5'(LIST_DEPTH);

    // Chunk arithmetic
    assign cur_inc = {1'b0, cur_reg} + 6'd1;
    assign src_sum = rd_desc_reg.source + off_reg;
    assign rem_le  = (rem_reg <= budget_reg);
    assign moved   = rem_le ? rem_reg : budget_reg;
    assign done    = rem_le && (cur_inc >= {1'b0, eff_len});
    assign stop    = done || !(rem_reg < budget_reg) || (n_reg == NW'(MAX_RESULTS - 1));

    assign out_space = !out_valid_reg || pop;

    // Descriptor memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            desc_mem[AW'(cmd.index)] <= '{packed_offset: cmd.packed_offset,
                                          length:        cmd.length,
                                          source:        cmd.source};
        end
        if (mem_re)
        begin
            rd_desc_reg <= desc_mem[AW'(cur_reg)];
        end
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        active_next = active_reg;
        cur_next    = cur_reg;
        off_next    = off_reg;
        pos_next    = pos_reg;
        budget_next = budget_reg;
        n_next      = n_reg;
        src_next    = src_reg;
        packed_next = packed_reg;
        rem_next    = rem_reg;
        err_next    = err_reg;
        fin_next    = fin_reg;
        cmd_pop     = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        out_push    = 1'b0;
        res_next    = '0;

        unique case (state_reg)
            B_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.op)
                        OP_WRITE:
                        begin
                            mem_we = 1'b1;
                        end
                        OP_ACTIVATE:
                        begin
                            active_next = 1'b1;
                            cur_next    = '0;
                            off_next    = '0;
                        end
                        OP_PASS:
                        begin
                            budget_next = cfg.bytes_per_pass;
                            n_next      = '0;
                            fin_next    = !active_reg;
                            if (!active_reg || (cfg.bytes_per_pass == 32'd0))
                            begin
                                state_next = B_NOTE;
                            end
                            else
                            begin
                                state_next = B_FETCH;
                            end
                        end
                        default:
                        begin
                            state_next = B_IDLE;
                        end
                    endcase
                end
            end

            // Inactive stream or zero budget: single empty word
            B_NOTE:
            begin
                if (out_space)
                begin
                    out_push                 = 1'b1;
                    res_next.stream_position = pos_reg;
                    res_next.finished        = fin_reg;
                    res_next.error_code      = ERR_NONE;
                    res_next.last            = 1'b1;
                    state_next               = B_IDLE;
                end
            end

            B_FETCH:
            begin
                if (cur_reg >= eff_len)
                begin
                    err_next   = ERR_PAST_LIST;
                    state_next = B_FAULT;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = B_CHECK;
                end
            end

            B_CHECK:
            begin
                src_next    = src_sum;
                packed_next = rd_desc_reg.packed_offset + off_reg;
                rem_next    = rd_desc_reg.length - off_reg;
                if (off_reg >= rd_desc_reg.length)
                begin
                    err_next   = ERR_OFFSET;
                    state_next = B_FAULT;
                end
                else if (src_sum == 32'd0)
                begin
                    err_next   = ERR_NULL_SOURCE;
                    state_next = B_FAULT;
                end
                else
                begin
                    state_next = B_EMIT;
                end
            end

            B_EMIT:
            begin
                if (out_space)
                begin
                    out_push                 = 1'b1;
                    res_next.copy_source     = src_reg;
                    res_next.copy_dest       = cfg.base_address + packed_reg;
                    res_next.copy_bytes      = moved;
                    res_next.stream_position = packed_reg + moved;
                    res_next.finished        = done;
                    res_next.error_code      = ERR_NONE;
                    res_next.last            = stop;
                    pos_next                 = packed_reg + moved;
                    budget_next              = budget_reg - moved;
                    n_next                   = n_reg + 1'b1;
                    if (rem_le)
                    begin
                        cur_next = cur_inc[4:0];
                        off_next = '0;
                    end
                    else
                    begin
                        off_next = off_reg + budget_reg;
                    end
                    if (done)
                    begin
                        active_next = 1'b0;
                    end
                    state_next = stop ? B_IDLE : B_FETCH;
                end
            end

            // Failed check: report and stop the stream, cursor kept
            B_FAULT:
            begin
                if (out_space)
                begin
                    out_push                 = 1'b1;
                    res_next.stream_position = pos_reg;
                    res_next.finished        = 1'b0;
                    res_next.error_code      = err_reg;
                    res_next.last            = 1'b1;
                    active_next              = 1'b0;
                    state_next               = B_IDLE;
                end
            end

            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            active_reg <= 1'b0;
            cur_reg    <= '0;
            off_reg    <= '0;
            pos_reg    <= '0;
            budget_reg <= '0;
            n_reg      <= '0;
            src_reg    <= '0;
            packed_reg <= '0;
            rem_reg    <= '0;
            err_reg    <= ERR_NONE;
            fin_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            active_reg <= active_next;
            cur_reg    <= cur_next;
            off_reg    <= off_next;
            pos_reg    <= pos_next;
            budget_reg <= budget_next;
            n_reg      <= n_next;
            src_reg    <= src_next;
            packed_reg <= packed_next;
            rem_reg    <= rem_next;
            err_reg    <= err_next;
            fin_reg    <= fin_next;
        end
    end

    // Output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_push)
        begin
            res_reg <= res_next;
        end
    end

    assign empty  = !out_valid_reg;
    assign result = res_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> (!out_valid_reg || pop))
        else $error("result word overwritten before it was taken");

    a_chunk_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_EMIT && out_push) |-> (res_next.copy_bytes != 32'd0))
        else $error("copy word with zero bytes");

    a_error_ends_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (out_push && res_next.error_code != ERR_NONE) |-> res_next.last)
        else $error("error word not marked last");

    a_check_after_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_CHECK) |-> ($past(state_reg) == B_FETCH))
        else $error("descriptor check without a memory read");
`endif

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import gdlw_pkg::*;

    localparam int         DEPTH           = LIST_DEPTH_DEF;
    localparam logic [1:0] MODE_UNKNOWN    = 2'd3;
    localparam int         SETTLE_CYCLES   = 24;
    localparam int         CYCLE_LIMIT     = 400000;
    localparam int         RANDOM_PHASES   = 8;
    localparam int         WORDS_PER_PHASE = 23;
    localparam int         MAX_PRINTS      = 40;

    // One input word as the producer sees it
    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  index;
        logic [31:0] packed_offset;
        logic [31:0] length;
        logic [31:0] source;
    } in_word_t;

    typedef enum logic { ROW_REG, ROW_WORD } row_kind_t;

    // Directed stimulus row: a register write or an input word
    typedef struct {
        row_kind_t   kind;
        logic [1:0]  reg_index;
        logic [31:0] reg_value;
        in_word_t    word;
        bit          typed;
        res_t        want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  mode = MODE_WRITE;
    logic [3:0]  entry_index = '0;
    logic [31:0] entry_packed_offset = '0;
    logic [31:0] entry_length = '0;
    logic [31:0] entry_source = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [31:0] copy_source;
    logic [31:0] copy_dest;
    logic [31:0] copy_bytes;
    logic [31:0] stream_position;
    logic        finished;
    logic [1:0]  error_code;
    logic        last;

    gather_dma_list_walker i_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .push                (push),
        .full                (full),
        .mode                (mode),
        .entry_index         (entry_index),
        .entry_packed_offset (entry_packed_offset),
        .entry_length        (entry_length),
        .entry_source        (entry_source),
        .empty               (empty),
        .pop                 (pop),
        .copy_source         (copy_source),
        .copy_dest           (copy_dest),
        .copy_bytes          (copy_bytes),
        .stream_position     (stream_position),
        .finished            (finished),
        .error_code          (error_code),
        .last                (last)
    );

    // Walker shadow: descriptor slots, cursor and registers
    desc_t       slot_mem [DEPTH];
    bit          slot_valid [DEPTH];
    logic        walk_active = 1'b0;
    logic [4:0]  walk_entry = '0;
    logic [31:0] walk_offset = '0;
    logic [31:0] walk_position = '0;
    cfg_t        cfg_shadow = '0;

    res_t        pass_words [$];
    res_t        copy_words_due [$];
    stim_row_t   stim_rows [$];

    bit          push_gaps = 1'b0;
    bit          pop_gaps = 1'b0;
    int          fail_count = 0;
    int          cycle_count = 0;
    int          words_sent = 0;
    int          passes_sent = 0;
    int          copy_words_seen = 0;
    int          finished_seen = 0;
    int          err_seen [4] = '{0, 0, 0, 0};

    always #1 clk = ~clk;

    // Hard stop on a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fail_count < MAX_PRINTS)
            $display("%0t MISMATCH %s: got %h expected %h", $realtime, what, got, want);
        fail_count++;
    endtask

    function automatic res_t make_res(input logic [31:0] src, input logic [31:0] dst,
                                      input logic [31:0] bytes, input logic [31:0] pos,
                                      input logic fin, input logic [1:0] err,
                                      input logic lst);
        res_t r;
        r.copy_source     = src;
        r.copy_dest       = dst;
        r.copy_bytes      = bytes;
        r.stream_position = pos;
        r.finished        = fin;
        r.error_code      = err;
        r.last            = lst;
        return r;
    endfunction

    function automatic in_word_t desc_word(input logic [3:0] idx, input logic [31:0] off,
                                           input logic [31:0] len, input logic [31:0] src);
        return '{MODE_WRITE, idx, off, len, src};
    endfunction

    function automatic in_word_t op_word(input logic [1:0] m);
        return '{m, 4'h0, 32'h0, 32'h0, 32'h0};
    endfunction

    function automatic logic [4:0] effective_length();
        return (cfg_shadow.list_length < 5'(DEPTH)) ? cfg_shadow.list_length : 5'(DEPTH);
    endfunction

    // Update the shadow for one accepted word; copy words of a pass land in pass_words
    task automatic predict_word(input in_word_t w);
        logic [4:0]  eff_len;
        logic [4:0]  e;
        logic [31:0] budget;
        logic [31:0] src;
        logic [31:0] packed_pos;
        logic [31:0] remaining;
        logic [31:0] moved;
        logic        done;
        pass_words.delete();
        eff_len = effective_length();
        case (w.mode)
            MODE_WRITE:
            begin
                slot_mem[w.index]   = '{w.packed_offset, w.length, w.source};
                slot_valid[w.index] = 1'b1;
            end
            MODE_ACTIVATE:
            begin
                walk_active = 1'b1;
                walk_entry  = '0;
                walk_offset = '0;
            end
            MODE_PASS:
            begin
                if (!walk_active)
                    pass_words.push_back(make_res(0, 0, 0, walk_position, 1'b1, ERR_NONE, 1'b0));
                else
                begin
                    budget = cfg_shadow.bytes_per_pass;
                    if (budget == 0)
                        pass_words.push_back(make_res(0, 0, 0, walk_position, 1'b0, ERR_NONE,
                                                      1'b0));
                    while (budget != 0 && pass_words.size() < MAX_RESULTS)
                    begin
                        e = walk_entry;
                        // checks run in order: past list, offset, null source
                        if (e >= eff_len)
                        begin
                            pass_words.push_back(make_res(0, 0, 0, walk_position, 1'b0,
                                                          ERR_PAST_LIST, 1'b0));
                            walk_active = 1'b0;
                            break;
                        end
                        if (walk_offset >= slot_mem[e[3:0]].length)
                        begin
                            pass_words.push_back(make_res(0, 0, 0, walk_position, 1'b0,
                                                          ERR_OFFSET, 1'b0));
                            walk_active = 1'b0;
                            break;
                        end
                        src = slot_mem[e[3:0]].source + walk_offset;
                        if (src == 0)
                        begin
                            pass_words.push_back(make_res(0, 0, 0, walk_position, 1'b0,
                                                          ERR_NULL_SOURCE, 1'b0));
                            walk_active = 1'b0;
                            break;
                        end
                        packed_pos = slot_mem[e[3:0]].packed_offset + walk_offset;
                        remaining  = slot_mem[e[3:0]].length - walk_offset;
                        done       = 1'b0;
                        if (remaining <= budget)
                        begin
                            moved       = remaining;
                            walk_entry  = e + 5'd1;
                            walk_offset = '0;
                            if (e + 5'd1 >= eff_len)
                            begin
                                walk_active = 1'b0;
                                done        = 1'b1;
                            end
                        end
                        else
                        begin
                            moved       = budget;
                            walk_offset = walk_offset + budget;
                        end
                        walk_position = packed_pos + moved;
                        pass_words.push_back(make_res(src, cfg_shadow.base_address + packed_pos,
                                                      moved, walk_position, done, ERR_NONE,
                                                      1'b0));
                        if (done)
                            break;
                        budget = budget - moved;
                    end
                end
                pass_words[pass_words.size() - 1].last = 1'b1;
            end
            default: ;
        endcase
    endtask

    // Push one word; on acceptance queue what it should produce
    task automatic send_word(input in_word_t w, input bit typed, input res_t want);
        int gap;
        gap = push_gaps ? $urandom_range(0, 4) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
        @(negedge clk);
        push                <= 1'b1;
        mode                <= w.mode;
        entry_index         <= w.index;
        entry_packed_offset <= w.packed_offset;
        entry_length        <= w.length;
        entry_source        <= w.source;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_word(w);
        words_sent++;
        if (w.mode == MODE_PASS)
            passes_sent++;
        if (typed)
            copy_words_due.push_back(want);
        else
            foreach (pass_words[i])
                copy_words_due.push_back(pass_words[i]);
    endtask

    // Drop push, wait for every expected word, then let the queue drain
    task automatic settle();
        @(negedge clk);
        push <= 1'b0;
        while (copy_words_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // APB write followed by a read-back of the same register
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] back;
        logic [31:0] stored;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        back = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_BASE_ADDRESS:   cfg_shadow.base_address = value;
            REG_BYTES_PER_PASS: cfg_shadow.bytes_per_pass = value;
            default:            cfg_shadow.list_length = value[4:0];
        endcase
        stored = (idx == REG_LIST_LENGTH) ? {27'h0, value[4:0]} : value;
        if (back !== stored)
            report_mismatch($sformatf("register %0d read-back", idx), back, stored);
    endtask

    // Random descriptor, biased to short lengths with the odd error case
    function automatic in_word_t random_desc(input logic [3:0] idx);
        logic [31:0] len;
        logic [31:0] src;
        int          pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            len = 32'h0;
        else if (pick == 1)
            len = $urandom;
        else
            len = $urandom_range(1, 64);
        pick = $urandom_range(0, 29);
        if (pick == 0)
            src = 32'h0;
        else if (pick == 1)
            src = 32'h0 - 32'($urandom_range(1, 8));
        else
            src = $urandom;
        return desc_word(idx, $urandom, len, src);
    endfunction

    task automatic add_reg(input logic [1:0] idx, input logic [31:0] value);
        stim_row_t row;
        row.kind      = ROW_REG;
        row.reg_index = idx;
        row.reg_value = value;
        row.word      = '0;
        row.typed     = 1'b0;
        row.want      = '0;
        stim_rows.push_back(row);
    endtask

    task automatic add_word(input in_word_t w, input bit typed, input res_t want);
        stim_row_t row;
        row.kind      = ROW_WORD;
        row.reg_index = '0;
        row.reg_value = '0;
        row.word      = w;
        row.typed     = typed;
        row.want      = want;
        stim_rows.push_back(row);
    endtask

    // Result side: random pop stalls, field compare against the oldest expectation
    initial
    begin : drain_results
        int   stall;
        res_t got;
        res_t want;
        @(posedge rst_n);
        forever
        begin
            stall = pop_gaps ? $urandom_range(0, 4) : 0;
            repeat (stall)
            begin
                @(negedge clk);
                pop <= 1'b0;
            end
            @(negedge clk);
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
            got = make_res(copy_source, copy_dest, copy_bytes, stream_position, finished,
                           error_code, last);
            copy_words_seen++;
            err_seen[got.error_code]++;
            if (got.finished)
                finished_seen++;
            if (copy_words_due.size() == 0)
                report_mismatch("copy word with none expected", got.copy_source, 32'h0);
            else
            begin
                want = copy_words_due.pop_front();
                if (got.copy_source !== want.copy_source)
                    report_mismatch("copy_source", got.copy_source, want.copy_source);
                if (got.copy_dest !== want.copy_dest)
                    report_mismatch("copy_dest", got.copy_dest, want.copy_dest);
                if (got.copy_bytes !== want.copy_bytes)
                    report_mismatch("copy_bytes", got.copy_bytes, want.copy_bytes);
                if (got.stream_position !== want.stream_position)
                    report_mismatch("stream_position", got.stream_position,
                                    want.stream_position);
                if (got.finished !== want.finished)
                    report_mismatch("finished", 32'(got.finished), 32'(want.finished));
                if (got.error_code !== want.error_code)
                    report_mismatch("error_code", 32'(got.error_code), 32'(want.error_code));
                if (got.last !== want.last)
                    report_mismatch("last", 32'(got.last), 32'(want.last));
            end
        end
    end

    // Stimulus
    initial
    begin : stimulus
        logic [4:0] eff_len;
        int         pick;
        in_word_t   w;
        logic [31:0] base_val;
        logic [31:0] budget_val;
        logic [31:0] length_val;

        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: inactive, zero budget, each error, wraps and full-range values
        add_word(op_word(MODE_PASS), 1'b1, make_res(0, 0, 0, 0, 1'b1, ERR_NONE, 1'b1));
        add_word(op_word(MODE_ACTIVATE), 1'b0, '0);
        add_word(op_word(MODE_PASS), 1'b1, make_res(0, 0, 0, 0, 1'b0, ERR_NONE, 1'b1));
        add_reg(REG_BYTES_PER_PASS, 32'd5);
        add_word(op_word(MODE_PASS), 1'b1, make_res(0, 0, 0, 0, 1'b0, ERR_PAST_LIST, 1'b1));
        add_word('{MODE_UNKNOWN, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, '0);
        add_reg(REG_LIST_LENGTH, 32'd3);
        add_word(desc_word(4'd0, 32'h0, 32'h0, 32'h10), 1'b0, '0);
        add_word(op_word(MODE_ACTIVATE), 1'b0, '0);
        add_word(op_word(MODE_PASS), 1'b1, make_res(0, 0, 0, 0, 1'b0, ERR_OFFSET, 1'b1));
        add_word(desc_word(4'd0, 32'h0, 32'h4, 32'h0), 1'b0, '0);
        add_word(op_word(MODE_ACTIVATE), 1'b0, '0);
        add_word(op_word(MODE_PASS), 1'b1, make_res(0, 0, 0, 0, 1'b0, ERR_NULL_SOURCE, 1'b1));
        // source plus offset wraps to zero on the second pass
        add_reg(REG_BYTES_PER_PASS, 32'd2);
        add_word(desc_word(4'd0, 32'h0, 32'h4, 32'hFFFF_FFFE), 1'b0, '0);
        add_word(op_word(MODE_ACTIVATE), 1'b0, '0);
        add_word(op_word(MODE_PASS), 1'b0, '0);
        add_word(op_word(MODE_PASS), 1'b0, '0);
        // full budget, destination wrap, entry split across passes
        add_reg(REG_BASE_ADDRESS, 32'hFFFF_FFF0);
        add_reg(REG_BYTES_PER_PASS, 32'hFFFF_FFFF);
        add_word(desc_word(4'd0, 32'h0, 32'h10, 32'h1000), 1'b0, '0);
        add_word(desc_word(4'd1, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF), 1'b0, '0);
        add_word(desc_word(4'd2, 32'h20, 32'hFFFF_FFFF, 32'h8000_0000), 1'b0, '0);
        add_word(op_word(MODE_ACTIVATE), 1'b0, '0);
        add_word(op_word(MODE_PASS), 1'b0, '0);
        add_word(op_word(MODE_PASS), 1'b0, '0);
        add_word(op_word(MODE_PASS), 1'b0, '0);

        foreach (stim_rows[i])
        begin
            if (stim_rows[i].kind == ROW_REG)
            begin
                settle();
                write_reg(stim_rows[i].reg_index, stim_rows[i].reg_value);
            end
            else
                send_word(stim_rows[i].word, stim_rows[i].typed, stim_rows[i].want);
        end

        // Random phases, each with its own register setting
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            settle();
            push_gaps = (ph == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
            pop_gaps  = (ph == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 9);
            case (ph)
                0:
                begin
                    base_val   = 32'hFFFF_FFFF;
                    budget_val = 32'hFFFF_FFFF;
                    length_val = 32'd16;
                end
                1:
                begin
                    base_val   = 32'h0;
                    budget_val = 32'd1;
                    length_val = 32'd1;
                end
                2:
                begin
                    base_val   = $urandom;
                    budget_val = $urandom_range(1, 4096);
                    length_val = 32'd31;
                end
                default:
                begin
                    base_val = $urandom;
                    if (pick == 0)
                        budget_val = 32'h0;
                    else if (pick < 6)
                        budget_val = $urandom_range(1, 48);
                    else if (pick < 8)
                        budget_val = $urandom_range(49, 4096);
                    else if (pick == 8)
                        budget_val = $urandom;
                    else
                        budget_val = 32'hFFFF_FFFF;
                    pick = $urandom_range(0, 9);
                    if (pick == 0)
                        length_val = 32'd0;
                    else if (pick == 1)
                        length_val = $urandom_range(17, 31);
                    else
                        length_val = $urandom_range(1, 16);
                end
            endcase
            write_reg(REG_BASE_ADDRESS, base_val);
            write_reg(REG_BYTES_PER_PASS, budget_val);
            write_reg(REG_LIST_LENGTH, length_val);

            // every slot a pass can reach must hold a descriptor
            eff_len = effective_length();
            for (int s = 0; s < DEPTH; s++)
                if (s < eff_len && !slot_valid[s])
                    send_word(random_desc(4'(s)), 1'b0, '0);

            send_word(op_word(MODE_ACTIVATE), 1'b0, '0);
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 25)
                    w = random_desc(4'($urandom_range(0, DEPTH - 1)));
                else if (pick < 35)
                    w = op_word(MODE_ACTIVATE);
                else if (pick < 92)
                    w = op_word(MODE_PASS);
                else
                    w = '{MODE_UNKNOWN, 4'($urandom), $urandom, $urandom, $urandom};
                send_word(w, 1'b0, '0);
            end
        end

        settle();
        $display("Sent %0d input words including %0d passes; checked %0d copy words",
                 words_sent, passes_sent, copy_words_seen);
        $display("Copy words flagged finished: %0d; error words past/offset/null: %0d/%0d/%0d",
                 finished_seen, err_seen[ERR_PAST_LIST], err_seen[ERR_OFFSET],
                 err_seen[ERR_NULL_SOURCE]);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: sim.f
design/gdlw_pkg.sv
design/gdlw_front.sv
design/gdlw_cmd_queue.sv
design/gdlw_back.sv
design/gather_dma_list_walker.sv
verif/testbench.sv
